### rtl/core/bpmd_pkg.sv
`timescale 1ns / 1ps
// bpmd_pkg: shared types, constants and a helper for the B-tree page degree search.
// Used by bpmd_ctrl, bpmd_dp and btree_page_max_degree_unit. No dependencies.

package bpmd_pkg;

    localparam int PAGE_W  = 16;
    localparam int KEY_W   = 11;
    localparam int CPTR_W  = 7;
    localparam int DEG_W   = 15;
    localparam int SUM_W   = 27;
    localparam int INC_W   = 9;
    localparam int CPAD_W  = 4;

    localparam logic [CPTR_W-1:0] SEG_BYTES    = 7'd8;
    localparam logic [4:0]        MIN_TAIL_PAD = 5'd3;
    localparam logic [DEG_W-1:0]  FIRST_DEG    = 15'd2;
    localparam logic [DEG_W-1:0]  MAX_DEG_CAP  = 15'd16384;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEARCH
    } state_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic hit;
    } sts_t;

    // trailing pad: 8 - m, plus one more segment when it cannot hold the flag and size
    function automatic logic [4:0] tail_pad(input logic [2:0] m);
        logic [4:0] t;
        begin
            t = 5'd8 - {2'b00, m};
            if (t < MIN_TAIL_PAD)
            begin
                t = t + 5'd8;
            end
            return t;
        end
    endfunction

endpackage

### rtl/core/btree_page_max_degree_unit.sv
`timescale 1ns / 1ps
// btree_page_max_degree_unit: top level of the B-tree page degree search.
// Depends on bpmd_pkg, bpmd_ctrl and bpmd_dp.
//
// Usage:
//   Input channel in_valid / in_stall carries one request: page_bytes, key_bytes,
//   child_ptr_bytes. A request is taken when in_valid is high and in_stall is low.
//   Output channel out_valid / out_stall carries max_degree, taken when out_valid
//   is high and out_stall is low.
//   Sequence: the request is captured, the setup values are loaded, then one
//   trial per cycle for d = 2, 3, ... until the padded node size meets or passes
//   the page (or d reaches 16384); the result then goes to the output register
//   once that register is free, and the next request is taken after that. A
//   single trial adder and compare path does the search. One request is in work
//   at a time.
//   The output register decouples the two sides: a new request is taken while a
//   result still waits. If the receiver stalls when the next search is done, the
//   search holds its result until the output register frees.
//   Reset (rst_n low, asynchronous) returns to idle and drops out_valid; no
//   clearing pass is needed.

module btree_page_max_degree_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [bpmd_pkg::PAGE_W-1:0]        page_bytes,
    input  logic [bpmd_pkg::KEY_W-1:0]         key_bytes,
    input  logic [bpmd_pkg::CPTR_W-1:0]        child_ptr_bytes,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [bpmd_pkg::DEG_W-1:0]         max_degree
);

    bpmd_pkg::cmd_t cmd;
    bpmd_pkg::sts_t sts;

    bpmd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    bpmd_dp u_dp
    (
        .clk             (clk),
        .page_bytes      (page_bytes),
        .key_bytes       (key_bytes),
        .child_ptr_bytes (child_ptr_bytes),
        .cmd             (cmd),
        .sts             (sts),
        .max_degree      (max_degree)
    );

endmodule

### rtl/core/bpmd_ctrl.sv
`timescale 1ns / 1ps
// bpmd_ctrl: sequencing state machine and output valid for the degree search.
// Depends on bpmd_pkg; drives bpmd_dp through cmd_t and reads sts_t.

module bpmd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output bpmd_pkg::cmd_t   cmd,
    input  bpmd_pkg::sts_t   sts
);

    bpmd_pkg::state_t state_reg;
    bpmd_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpmd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bpmd_pkg::ST_LOAD;
                end
            end
            bpmd_pkg::ST_LOAD:
            begin
                state_next = bpmd_pkg::ST_SEARCH;
            end
            bpmd_pkg::ST_SEARCH:
            begin
                if (sts.hit && out_free)
                begin
                    state_next = bpmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpmd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            bpmd_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            bpmd_pkg::ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            bpmd_pkg::ST_SEARCH:
            begin
                cmd.step     = !sts.hit;
                cmd.load_out = sts.hit && out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpmd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/bpmd_dp.sv
`timescale 1ns / 1ps
// bpmd_dp: operand registers, per-degree running sums, trial compare and result register.
// Depends on bpmd_pkg; controlled by bpmd_ctrl through cmd_t / sts_t.

module bpmd_dp
(
    input  logic                               clk,
    input  logic [bpmd_pkg::PAGE_W-1:0]        page_bytes,
    input  logic [bpmd_pkg::KEY_W-1:0]         key_bytes,
    input  logic [bpmd_pkg::CPTR_W-1:0]        child_ptr_bytes,
    input  bpmd_pkg::cmd_t                     cmd,
    output bpmd_pkg::sts_t                     sts,
    output logic [bpmd_pkg::DEG_W-1:0]         max_degree
);

    logic [bpmd_pkg::PAGE_W-1:0] page_reg;
    logic [bpmd_pkg::KEY_W-1:0]  key_reg;
    logic [bpmd_pkg::CPTR_W-1:0] cptr_reg;
    logic [bpmd_pkg::SUM_W-1:0]  child_reg;
    logic [bpmd_pkg::SUM_W-1:0]  child_next;
    logic [bpmd_pkg::INC_W-1:0]  cinc_reg;
    logic [bpmd_pkg::SUM_W-1:0]  nk_reg;
    logic [bpmd_pkg::SUM_W-1:0]  nk_next;
    logic [bpmd_pkg::KEY_W:0]    key2_reg;
    logic [bpmd_pkg::CPAD_W-1:0] cpad_reg;
    logic [bpmd_pkg::DEG_W-1:0]  deg_reg;
    logic [bpmd_pkg::DEG_W-1:0]  deg_next;
    logic [bpmd_pkg::DEG_W-1:0]  max_degree_reg;

    // setup from the captured pointer size
    logic [bpmd_pkg::CPAD_W-1:0] cpad;
    logic [bpmd_pkg::INC_W-1:0]  cinc;
    logic [9:0]                  child0;
    logic [7:0]                  seg_span;
    logic [4:0]                  extra;

    always_comb
    begin
        cpad     = '0;
        extra    = '0;
        seg_span = '0;
        cinc     = '0;
        child0   = '0;
        if (cptr_reg > bpmd_pkg::SEG_BYTES)
        begin
            cpad     = 4'd8 - {1'b0, cptr_reg[2:0]};
            seg_span = {1'b0, cptr_reg} + {4'd0, cpad};
            cinc     = {seg_span, 1'b0};
            child0   = {1'b0, cinc} + {2'b00, seg_span} + {3'd0, cptr_reg};
        end
        else if (cptr_reg != '0)
        begin
            case (cptr_reg[3:0])
                4'd3:    begin cpad = 4'd2; extra = 5'd2; end
                4'd5:    begin cpad = 4'd3; extra = 5'd6; end
                4'd6:    begin cpad = 4'd2; extra = 5'd4; end
                4'd7:    begin cpad = 4'd1; extra = 5'd2; end
                default: begin cpad = 4'd0; extra = 5'd0; end
            endcase
            cinc   = {1'b0, cptr_reg, 1'b0} + {4'd0, extra};
            child0 = {cinc, 1'b0};
        end
    end

    // one trial at the current degree
    logic [bpmd_pkg::SUM_W-1:0] total;
    logic [2:0]                 tail_mod;
    logic                       over;
    logic                       exact;
    logic                       at_cap;

    assign tail_mod = nk_reg[2:0] - cpad_reg[2:0];
    assign total    = child_reg + nk_reg
                    + {{(bpmd_pkg::SUM_W-bpmd_pkg::CPAD_W){1'b0}}, cpad_reg}
                    + {{(bpmd_pkg::SUM_W-5){1'b0}}, bpmd_pkg::tail_pad(tail_mod)};
    assign over     = total > {{(bpmd_pkg::SUM_W-bpmd_pkg::PAGE_W){1'b0}}, page_reg};
    assign exact    = total == {{(bpmd_pkg::SUM_W-bpmd_pkg::PAGE_W){1'b0}}, page_reg};
    assign at_cap   = deg_reg == bpmd_pkg::MAX_DEG_CAP;
    assign sts.hit  = over || exact || at_cap;

    always_comb
    begin
        child_next = child_reg;
        nk_next    = nk_reg;
        deg_next   = deg_reg;
        if (cmd.load)
        begin
            child_next = {{(bpmd_pkg::SUM_W-10){1'b0}}, child0};
            nk_next    = {{(bpmd_pkg::SUM_W-bpmd_pkg::KEY_W-2){1'b0}},
                          {1'b0, key_reg, 1'b0} + {2'b00, key_reg}};
            deg_next   = bpmd_pkg::FIRST_DEG;
        end
        else if (cmd.step)
        begin
            child_next = child_reg + {{(bpmd_pkg::SUM_W-bpmd_pkg::INC_W){1'b0}}, cinc_reg};
            nk_next    = nk_reg + {{(bpmd_pkg::SUM_W-bpmd_pkg::KEY_W-1){1'b0}}, key2_reg};
            deg_next   = deg_reg + 15'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg <= page_bytes;
            key_reg  <= key_bytes;
            cptr_reg <= child_ptr_bytes;
        end
        if (cmd.load)
        begin
            cinc_reg <= cinc;
            key2_reg <= {key_reg, 1'b0};
            cpad_reg <= cpad;
        end
        child_reg <= child_next;
        nk_reg    <= nk_next;
        deg_reg   <= deg_next;
        if (cmd.load_out)
        begin
            max_degree_reg <= over ? (deg_reg - 15'd1) : deg_reg;
        end
    end

    assign max_degree = max_degree_reg;

endmodule

### sim/btree_page_max_degree_check.sv
`timescale 1ns / 1ps
// btree_page_max_degree_check: watches both channels of the page degree search,
// predicts max_degree for each accepted request and compares results in order.
// Depends on bpmd_pkg for port widths only.

module btree_page_max_degree_check
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [bpmd_pkg::PAGE_W-1:0]        page_bytes,
    input  logic [bpmd_pkg::KEY_W-1:0]         key_bytes,
    input  logic [bpmd_pkg::CPTR_W-1:0]        child_ptr_bytes,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [bpmd_pkg::DEG_W-1:0]         max_degree,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 requests_seen,
    output int                                 results_checked,
    output int                                 cap_hits,
    output int                                 floor_hits
);

    localparam int unsigned SEG_LEN   = 8;
    localparam int unsigned TAIL_MIN  = 3;
    localparam int unsigned START_DEG = 2;
    localparam int unsigned DEG_LIMIT = 16384;
    localparam int          REPORT_MAX = 10;

    typedef struct packed {
        logic [bpmd_pkg::PAGE_W-1:0] page;
        logic [bpmd_pkg::KEY_W-1:0]  key;
        logic [bpmd_pkg::CPTR_W-1:0] cptr;
        logic [bpmd_pkg::DEG_W-1:0]  degree;
    } degree_entry_t;

    degree_entry_t expected_degrees[$];
    degree_entry_t head;
    degree_entry_t fresh;
    int            mismatches = 0;
    int            n_requests = 0;
    int            n_results  = 0;
    int            n_cap      = 0;
    int            n_floor    = 0;

    // bytes taken by one node of degree d: padded child pointers, keys, tail pad
    function automatic int unsigned node_size(int unsigned d, int unsigned k, int unsigned c);
        int unsigned n;
        int unsigned cpad;
        int unsigned total;
        int unsigned tpad;
        int unsigned per_seg;
        begin
            n     = 2 * d - 1;
            cpad  = 0;
            total = 0;
            if (c > SEG_LEN)
            begin
                cpad  = SEG_LEN - (c % SEG_LEN);
                total = n * (c + cpad) + c;
            end
            else if (c != 0)
            begin
                per_seg = SEG_LEN / c;
                cpad    = SEG_LEN % c;
                total   = 2 * d * c + cpad * ((2 * d) / per_seg);
            end
            total = total + n * k + cpad;
            // wraps below zero like the hardware: 2^32 is a multiple of 8
            tpad = SEG_LEN - ((n * k - cpad) % SEG_LEN);
            if (tpad >= TAIL_MIN)
            begin
                total = total + tpad;
            end
            else
            begin
                total = total + tpad + SEG_LEN;
            end
            return total;
        end
    endfunction

    function automatic logic [bpmd_pkg::DEG_W-1:0] search_max_degree(
        int unsigned page, int unsigned k, int unsigned c);
        int unsigned d;
        int unsigned used;
        int unsigned best;
        begin
            best = DEG_LIMIT;
            for (d = START_DEG; d <= DEG_LIMIT; d++)
            begin
                used = node_size(d, k, c);
                if (used > page)
                begin
                    best = d - 1;
                    break;
                end
                if (used == page)
                begin
                    best = d;
                    break;
                end
            end
            return best[bpmd_pkg::DEG_W-1:0];
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // retire the oldest expectation before queuing a new request
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (expected_degrees.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("[%0t] unexpected result: max_degree=%0d", $realtime,
                                 max_degree);
                    end
                end
                else
                begin
                    head = expected_degrees.pop_front();
                    if (max_degree !== head.degree)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("[%0t] max_degree mismatch: page=%0d key=%0d cptr=%0d exp=%0d got=%0d",
                                     $realtime, head.page, head.key, head.cptr,
                                     head.degree, max_degree);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                fresh.page   = page_bytes;
                fresh.key    = key_bytes;
                fresh.cptr   = child_ptr_bytes;
                fresh.degree = search_max_degree(page_bytes, key_bytes, child_ptr_bytes);
                if (fresh.degree == DEG_LIMIT[bpmd_pkg::DEG_W-1:0])
                begin
                    n_cap++;
                end
                if (fresh.degree <= 1)
                begin
                    n_floor++;
                end
                expected_degrees.push_back(fresh);
                n_requests++;
            end
        end
        fail_count      <= mismatches;
        pending         <= expected_degrees.size();
        requests_seen   <= n_requests;
        results_checked <= n_results;
        cap_hits        <= n_cap;
        floor_hits      <= n_floor;
    end

endmodule

### sim/btree_page_max_degree_unit_test.sv
`timescale 1ns / 1ps
// btree_page_max_degree_unit_test: clock, reset and request traffic for the page
// degree search, with random stalls on both sides. Depends on bpmd_pkg, the unit
// and btree_page_max_degree_check, which predicts and compares the results.

module btree_page_max_degree_unit_test;

    localparam int RANDOM_ITEMS   = 70;
    localparam int CALM_ITEMS     = 20;
    localparam int PRESSURE_ITEMS = 6;
    localparam int DIRECTED_MAX   = 25;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int SEARCH_WORST   = 16387;
    localparam int CYCLE_LIMIT    =
        (DIRECTED_MAX + RANDOM_ITEMS + PRESSURE_ITEMS) * (SEARCH_WORST + 30) * 3
        + HOLD_CYCLES * 3 + 1000;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [bpmd_pkg::PAGE_W-1:0]   page_bytes;
    logic [bpmd_pkg::KEY_W-1:0]    key_bytes;
    logic [bpmd_pkg::CPTR_W-1:0]   child_ptr_bytes;
    logic                          out_valid;
    logic                          out_stall;
    logic [bpmd_pkg::DEG_W-1:0]    max_degree;

    int fail_count;
    int pending;
    int requests_seen;
    int results_checked;
    int cap_hits;
    int floor_hits;
    int cycle_count = 0;

    bit calm     = 1'b0;
    bit gaps_on  = 1'b1;
    bit hold_req = 1'b0;
    bit holding  = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    btree_page_max_degree_unit u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .page_bytes      (page_bytes),
        .key_bytes       (key_bytes),
        .child_ptr_bytes (child_ptr_bytes),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .max_degree      (max_degree)
    );

    btree_page_max_degree_check u_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .page_bytes      (page_bytes),
        .key_bytes       (key_bytes),
        .child_ptr_bytes (child_ptr_bytes),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .max_degree      (max_degree),
        .fail_count      (fail_count),
        .pending         (pending),
        .requests_seen   (requests_seen),
        .results_checked (results_checked),
        .cap_hits        (cap_hits),
        .floor_hits      (floor_hits)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // offers one request and holds it until taken
    task automatic send_request(input logic [bpmd_pkg::PAGE_W-1:0] page,
                                input logic [bpmd_pkg::KEY_W-1:0]  key,
                                input logic [bpmd_pkg::CPTR_W-1:0] cptr);
        begin
            if (gaps_on && !calm && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            in_valid        <= 1'b1;
            page_bytes      <= page;
            key_bytes       <= key;
            child_ptr_bytes <= cptr;
            @(posedge clk);
            while (in_stall)
            begin
                @(posedge clk);
            end
        end
    endtask

    task automatic send_random_request();
        logic [bpmd_pkg::PAGE_W-1:0] page;
        logic [bpmd_pkg::KEY_W-1:0]  key;
        logic [bpmd_pkg::CPTR_W-1:0] cptr;
        int                          pick;
        begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
            begin
                page = $urandom_range(64, 8191);
                key  = $urandom_range(3, 1024);
                cptr = $urandom_range(1, 64);
            end
            else if (pick < 17)
            begin
                page = $urandom;
                key  = $urandom;
                cptr = $urandom;
            end
            else
            begin
                // tiny keys drive the search deep, sometimes to the cap
                page = $urandom;
                key  = $urandom_range(0, 15);
                cptr = $urandom_range(0, 16);
            end
            send_request(page, key, cptr);
        end
    endtask

    initial
    begin
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req && !calm)
            begin
                out_stall <= 1'b1;
                holding = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holding  = 1'b0;
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        page_bytes      <= '0;
        key_bytes       <= '0;
        child_ptr_bytes <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes
        send_request(16'd64, 11'd3, 7'd1);
        send_request(16'd65535, 11'd1024, 7'd64);
        send_request(16'd65535, 11'd3, 7'd1);
        send_request(16'd64, 11'd1024, 7'd64);
        send_request(16'hFFFF, 11'h7FF, 7'h7F);
        send_request(16'd0, 11'd0, 7'd0);
        // no pointers: node is always 8 bytes, exact at 8, cap on a large page
        send_request(16'd8, 11'd0, 7'd0);
        send_request(16'd65535, 11'd0, 7'd0);
        // key span shorter than the child pad, remainder taken below zero
        send_request(16'd200, 11'd0, 7'd9);
        send_request(16'd300, 11'd0, 7'd3);
        send_request(16'd500, 11'd1, 7'd16);
        // pointer sizes around the segment boundary
        send_request(16'd4096, 11'd40, 7'd3);
        send_request(16'd4096, 11'd40, 7'd5);
        send_request(16'd4096, 11'd40, 7'd7);
        send_request(16'd4096, 11'd40, 7'd8);
        send_request(16'd4096, 11'd40, 7'd9);
        send_request(16'd4096, 11'd40, 7'd16);
        // exact fits and their neighbours
        send_request(16'd64, 11'd8, 7'd8);
        send_request(16'd96, 11'd8, 7'd8);
        send_request(16'd95, 11'd8, 7'd8);
        send_request(16'd97, 11'd8, 7'd8);
        send_request(16'd152, 11'd16, 7'd16);
        // short tail pad needs an extra segment
        send_request(16'd1000, 11'd3, 7'd1);

        repeat ((RANDOM_ITEMS - CALM_ITEMS) / 2) send_random_request();

        // receiver holds off while requests keep coming
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        wait (holding);
        repeat (PRESSURE_ITEMS)
        begin
            send_request($urandom_range(64, 1024), $urandom_range(64, 1024),
                         $urandom_range(1, 64));
        end
        gaps_on = 1'b1;

        repeat ((RANDOM_ITEMS - CALM_ITEMS) / 2) send_random_request();

        calm = 1'b1;
        repeat (CALM_ITEMS) send_random_request();
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d requests, %0d results checked, %0d mismatches",
                 requests_seen, results_checked, fail_count);
        $display("Summary: %0d searches ran to the degree cap, %0d fit degree 1 or less",
                 cap_hits, floor_hits);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/bpmd_pkg.sv
rtl/core/bpmd_ctrl.sv
rtl/core/bpmd_dp.sv
rtl/core/btree_page_max_degree_unit.sv
sim/btree_page_max_degree_check.sv
sim/btree_page_max_degree_unit_test.sv
